// ----- rtl/lks_pkg.sv -----
`default_nettype none

package lks_pkg;

	// Fixed field widths.
	localparam int CFG_W   = 5;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register map: one register, selected by paddr[2].
	localparam logic REG_ENTRIES_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

	// Request operation codes.
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_ACCESS = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_UPDATED   = 3'd0,
		STAT_INS_FREE  = 3'd1,
		STAT_INS_EVICT = 3'd2,
		STAT_HIT       = 3'd3,
		STAT_MISS      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic issue;
		logic commit;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/lks_datapath.sv -----
`default_nettype none

module lks_datapath #(
	parameter int CAPACITY = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [lks_pkg::CFG_W-1:0]     entries_in_use,
	input  wire lks_pkg::dp_cmd_t              dp_cmd,
	output lks_pkg::dp_stat_t                  dp_stat,
	input  wire logic                          cmd,
	input  wire logic [lks_pkg::KEY_W-1:0]     key,
	input  wire logic signed [lks_pkg::VAL_W-1:0] value_in,
	output logic [lks_pkg::STAT_W-1:0]         status,
	output logic signed [lks_pkg::VAL_W-1:0]   value_out,
	output logic [lks_pkg::KEY_W-1:0]          evicted_key
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > lks_pkg::CFG_W) ? CNT_W : lks_pkg::CFG_W;

	// Entry storage.
	logic [lks_pkg::KEY_W-1:0] key_mem   [CAPACITY];
	logic [lks_pkg::VAL_W-1:0] value_mem [CAPACITY];
	logic                      valid_q   [CAPACITY];
	logic [RANK_W-1:0]         rank_q    [CAPACITY];

	// Captured request.
	logic                      req_cmd_q;
	logic [lks_pkg::KEY_W-1:0] req_key_q;
	logic [lks_pkg::VAL_W-1:0] req_value_q;

	// Scan pipeline.
	logic [IDX_W-1:0]          addr_q;
	logic                      rd_vld_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [lks_pkg::KEY_W-1:0] key_rd_s1;
	logic [lks_pkg::VAL_W-1:0] value_rd_s1;

	// Scan results.
	logic                      hit_found_q;
	logic [IDX_W-1:0]          hit_idx_q;
	logic [RANK_W-1:0]         hit_rank_q;
	logic [lks_pkg::VAL_W-1:0] hit_value_q;
	logic                      free_found_q;
	logic [IDX_W-1:0]          free_idx_q;
	logic                      vic_found_q;
	logic [IDX_W-1:0]          vic_idx_q;
	logic [RANK_W-1:0]         vic_rank_q;
	logic [lks_pkg::KEY_W-1:0] vic_key_q;

	// Result register.
	logic [lks_pkg::STAT_W-1:0] status_q;
	logic [lks_pkg::VAL_W-1:0]  value_out_q;
	logic [lks_pkg::KEY_W-1:0]  evicted_key_q;

	logic [CMP_W-1:0]          cfg_ext;
	logic [CMP_W-1:0]          n_active;
	logic [IDX_W-1:0]          last_idx;

	logic                      ent_valid;
	logic [RANK_W-1:0]         ent_rank;
	logic                      take_hit;
	logic                      take_free;
	logic                      take_vic;

	lks_pkg::status_t          st_next;
	logic [lks_pkg::VAL_W-1:0] vout_next;
	logic [lks_pkg::KEY_W-1:0] ekey_next;
	logic [IDX_W-1:0]          tgt_idx;
	logic [RANK_W-1:0]         touch_rank;
	logic                      do_touch;
	logic                      do_fill;
	logic                      do_key_wr;
	logic                      do_val_wr;

	// Active entry count, clamped to 1..CAPACITY.
	always_comb begin
		cfg_ext = CMP_W'(entries_in_use);
		if (cfg_ext == '0) begin
			n_active = CMP_W'(1);
		end else if (cfg_ext > CMP_W'(CAPACITY)) begin
			n_active = CMP_W'(CAPACITY);
		end else begin
			n_active = cfg_ext;
		end
		last_idx = IDX_W'(n_active - CMP_W'(1));
	end

	assign dp_stat.scan_last = (addr_q == last_idx);

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			req_cmd_q   <= cmd;
			req_key_q   <= key;
			req_value_q <= value_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= dp_cmd.issue;
			if (dp_cmd.load) begin
				addr_q <= '0;
			end else if (dp_cmd.issue) begin
				addr_q <= addr_q + IDX_W'(1);
			end
		end
	end

	// Key and value memories: one read a cycle while scanning, one write on commit.
	always_ff @(posedge clk) begin
		if (dp_cmd.issue) begin
			key_rd_s1   <= key_mem[addr_q];
			value_rd_s1 <= value_mem[addr_q];
			idx_s1      <= addr_q;
		end
		if (dp_cmd.commit && do_key_wr) begin
			key_mem[tgt_idx] <= req_key_q;
		end
		if (dp_cmd.commit && do_val_wr) begin
			value_mem[tgt_idx] <= req_value_q;
		end
	end

	assign ent_valid = valid_q[idx_s1];
	assign ent_rank  = rank_q[idx_s1];
	assign take_hit  = rd_vld_s1 && ent_valid && !hit_found_q && (key_rd_s1 == req_key_q);
	assign take_free = rd_vld_s1 && !ent_valid && !free_found_q;
	assign take_vic  = rd_vld_s1 && ent_valid && (!vic_found_q || (ent_rank > vic_rank_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
		end else if (dp_cmd.load) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
		end else begin
			if (take_hit) begin
				hit_found_q <= 1'b1;
			end
			if (take_free) begin
				free_found_q <= 1'b1;
			end
			if (take_vic) begin
				vic_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q   <= idx_s1;
			hit_rank_q  <= ent_rank;
			hit_value_q <= value_rd_s1;
		end
		if (take_free) begin
			free_idx_q <= idx_s1;
		end
		if (take_vic) begin
			vic_idx_q  <= idx_s1;
			vic_rank_q <= ent_rank;
			vic_key_q  <= key_rd_s1;
		end
	end

	// Decide the action once the scan is complete.
	always_comb begin
		st_next    = lks_pkg::STAT_UPDATED;
		vout_next  = '0;
		ekey_next  = '0;
		tgt_idx    = hit_idx_q;
		touch_rank = hit_rank_q;
		do_touch   = 1'b0;
		do_fill    = 1'b0;
		do_key_wr  = 1'b0;
		do_val_wr  = 1'b0;
		if (req_cmd_q == lks_pkg::CMD_ACCESS) begin
			if (hit_found_q) begin
				st_next   = lks_pkg::STAT_HIT;
				vout_next = hit_value_q;
				do_touch  = 1'b1;
			end else begin
				st_next = lks_pkg::STAT_MISS;
			end
		end else if (hit_found_q) begin
			st_next   = lks_pkg::STAT_UPDATED;
			do_val_wr = 1'b1;
			do_touch  = 1'b1;
		end else if (free_found_q) begin
			st_next   = lks_pkg::STAT_INS_FREE;
			tgt_idx   = free_idx_q;
			do_fill   = 1'b1;
			do_key_wr = 1'b1;
			do_val_wr = 1'b1;
		end else if (vic_found_q) begin
			st_next    = lks_pkg::STAT_INS_EVICT;
			tgt_idx    = vic_idx_q;
			touch_rank = vic_rank_q;
			ekey_next  = vic_key_q;
			do_touch   = 1'b1;
			do_key_wr  = 1'b1;
			do_val_wr  = 1'b1;
		end
	end

	// Valid bits and recency ranks, updated in parallel for every entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else if (dp_cmd.commit) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (do_touch) begin
					if (IDX_W'(i) == tgt_idx) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < touch_rank)) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end else if (do_fill) begin
					if (IDX_W'(i) == tgt_idx) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			status_q      <= st_next;
			value_out_q   <= vout_next;
			evicted_key_q <= ekey_next;
		end
	end

	assign status      = status_q;
	assign value_out   = value_out_q;
	assign evicted_key = evicted_key_q;

	a_fill_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.commit && do_fill |-> !valid_q[free_idx_q])
		else $error("insert targets an entry that is already valid");

	a_target_newest: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.commit && (do_fill || do_touch)
		|=> valid_q[$past(tgt_idx)] && (rank_q[$past(tgt_idx)] == '0))
		else $error("written or touched entry is not valid and most recent");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		take_hit |-> (idx_s1 <= last_idx))
		else $error("key match found outside the active entries");

	a_add_has_target: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.commit && (req_cmd_q == lks_pkg::CMD_ADD)
		|-> (hit_found_q || free_found_q || vic_found_q))
		else $error("add completed with no entry to write");

endmodule

`default_nettype wire

// ----- rtl/lks_ctrl.sv -----
`default_nettype none

module lks_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output lks_pkg::dp_cmd_t        dp_cmd,
	input  wire lks_pkg::dp_stat_t  dp_stat
);

	lks_pkg::state_t state_q;
	lks_pkg::state_t state_next;
	logic            rsp_valid_q;
	logic            rsp_free;

	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			lks_pkg::S_IDLE: begin
				if (req_valid) begin
					state_next = lks_pkg::S_SCAN;
				end
			end
			lks_pkg::S_SCAN: begin
				if (dp_stat.scan_last) begin
					state_next = lks_pkg::S_DRAIN;
				end
			end
			lks_pkg::S_DRAIN: begin
				state_next = lks_pkg::S_COMMIT;
			end
			lks_pkg::S_COMMIT: begin
				if (rsp_free) begin
					state_next = lks_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = lks_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready     = 1'b0;
		dp_cmd.load   = 1'b0;
		dp_cmd.issue  = 1'b0;
		dp_cmd.commit = 1'b0;
		unique case (state_q)
			lks_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				dp_cmd.load = req_valid;
			end
			lks_pkg::S_SCAN: begin
				dp_cmd.issue = 1'b1;
			end
			lks_pkg::S_DRAIN: begin
			end
			lks_pkg::S_COMMIT: begin
				dp_cmd.commit = rsp_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lks_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (dp_cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// ----- rtl/lru_keyed_store_core.sv -----
`default_nettype none

// Fully associative key-value store with least-recently-used replacement.
// An add request (cmd 0) updates the value of a stored key, or stores the key
// in the lowest-numbered free entry, or, when every active entry is taken,
// replaces the least recently used entry and returns its key. An access
// request (cmd 1) returns the stored value and makes the entry most recent,
// or reports a miss. Each request gives exactly one response. Only the first
// entries_in_use entries (clamped to 1..CAPACITY) are searched and filled.
// A request is processed by a linear scan of the key and value memories, one
// entry per clock, through the states accept (S_IDLE), scan (S_SCAN, one
// read per active entry), last compare (S_DRAIN) and commit (S_COMMIT);
// the commit waits while the output register still holds an unaccepted
// response. The next request can be accepted in the cycle after the commit,
// while the previous response may still wait in the output register.
// entries_in_use sits at byte address 0 of the APB-style port and must only
// be written while no request is in flight.
module lru_keyed_store_core #(
	parameter int CAPACITY = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration port.
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [lks_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [lks_pkg::PDATA_W-1:0]      pwdata,
	output logic [lks_pkg::PDATA_W-1:0]           prdata,
	output logic                                  pready,
	// Request channel.
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire logic                             cmd,
	input  wire logic [lks_pkg::KEY_W-1:0]        key,
	input  wire logic signed [lks_pkg::VAL_W-1:0] value_in,
	// Response channel.
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output logic [lks_pkg::STAT_W-1:0]            status,
	output logic signed [lks_pkg::VAL_W-1:0]      value_out,
	output logic [lks_pkg::KEY_W-1:0]             evicted_key
);

	logic [lks_pkg::CFG_W-1:0] entries_in_use_q;
	logic                      cfg_wr;
	lks_pkg::dp_cmd_t          dp_cmd;
	lks_pkg::dp_stat_t         dp_stat;

	// The port never inserts wait states.
	assign pready = 1'b1;

	// Word index is paddr[2]; the byte offset bits are ignored.
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == lks_pkg::REG_ENTRIES_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= lks_pkg::ENTRIES_RESET;
		end else if (cfg_wr) begin
			entries_in_use_q <= pwdata[lks_pkg::CFG_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == lks_pkg::REG_ENTRIES_IN_USE) begin
			prdata = lks_pkg::PDATA_W'(entries_in_use_q);
		end else begin
			prdata = '0;
		end
	end

	lks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	lks_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.entries_in_use (entries_in_use_q),
		.dp_cmd         (dp_cmd),
		.dp_stat        (dp_stat),
		.cmd            (cmd),
		.key            (key),
		.value_in       (value_in),
		.status         (status),
		.value_out      (value_out),
		.evicted_key    (evicted_key)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the LRU keyed store. Requests are driven on a
// valid/ready channel, each accepted request is run through a behavioral
// model of the store kept in this file, and the expected response is queued.
// Responses are compared field by field against the oldest queued entry.
module tb_top;

	localparam int CAPACITY    = 16;
	localparam int SETTLE      = 8;    // idle cycles after the last response
	localparam int PHASES      = 13;
	localparam int PHASE_ITEMS = 150;
	localparam int PLAN_ROWS   = 25;

	// entries_in_use is register 0, so it sits at byte address 0.
	localparam logic [lks_pkg::PADDR_W-1:0] ENTRIES_ADDR =
		{lks_pkg::REG_ENTRIES_IN_USE, 2'b00};

	typedef struct packed {
		lks_pkg::status_t          status;
		logic [lks_pkg::VAL_W-1:0] value_out;
		logic [lks_pkg::KEY_W-1:0] evicted_key;
	} lru_rsp_t;

	typedef enum logic {
		ROW_REQUEST,
		ROW_CONFIG
	} row_kind_t;

	// One row of the directed plan. For config rows the key field carries
	// the register value. Rows with fixed_rsp set carry a hand-written
	// expectation; all others are checked against the model.
	typedef struct packed {
		row_kind_t                 kind;
		logic                      cmd;
		logic [lks_pkg::KEY_W-1:0] key;
		logic [lks_pkg::VAL_W-1:0] value;
		bit                        fixed_rsp;
		lru_rsp_t                  rsp;
	} plan_row_t;

	localparam lru_rsp_t NO_RSP =
		'{status: lks_pkg::STAT_MISS, value_out: '0, evicted_key: '0};

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [lks_pkg::PADDR_W-1:0]      paddr = '0;
	logic [lks_pkg::PDATA_W-1:0]      pwdata = '0;
	logic [lks_pkg::PDATA_W-1:0]      prdata;
	logic                             pready;
	logic                             req_valid = 1'b0;
	logic                             req_ready;
	logic                             cmd = lks_pkg::CMD_ADD;
	logic [lks_pkg::KEY_W-1:0]        key = '0;
	logic signed [lks_pkg::VAL_W-1:0] value_in = '0;
	logic                             rsp_valid;
	logic                             rsp_ready = 1'b0;
	logic [lks_pkg::STAT_W-1:0]       status;
	logic signed [lks_pkg::VAL_W-1:0] value_out;
	logic [lks_pkg::KEY_W-1:0]        evicted_key;

	lru_keyed_store_core #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.cmd        (cmd),
		.key        (key),
		.value_in   (value_in),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.value_out  (value_out),
		.evicted_key(evicted_key)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin
		#20000000;
		$display("tb_top failed");
		$finish;
	end

	// Model of the store. Ranks are kept as plain integers; 0 is the most
	// recently used entry and the valid entries always hold 0..count-1.
	bit                        slot_valid [CAPACITY];
	logic [lks_pkg::KEY_W-1:0] slot_key   [CAPACITY];
	logic [lks_pkg::VAL_W-1:0] slot_value [CAPACITY];
	int                        slot_rank  [CAPACITY];
	logic [lks_pkg::CFG_W-1:0] entries_reg = lks_pkg::ENTRIES_RESET;

	lru_rsp_t pending_rsp [$];
	int       mismatch_count = 0;
	bit       calm = 1'b0;     // when set, neither side inserts idle cycles

	// Moves entry idx to rank 0; every valid entry that was more recent
	// than it ages by one.
	function automatic void make_recent(int idx);
		int old_rank;
		old_rank = slot_rank[idx];
		for (int i = 0; i < CAPACITY; i++) begin
			if (slot_valid[i] && slot_rank[i] < old_rank)
				slot_rank[i]++;
		end
		slot_rank[idx] = 0;
	endfunction

	function automatic lru_rsp_t lru_predict(logic op, logic [lks_pkg::KEY_W-1:0] k,
			logic [lks_pkg::VAL_W-1:0] v);
		int       active;
		int       hit;
		int       free_slot;
		int       victim;
		lru_rsp_t rsp;
		// A register value of zero behaves as one; anything above the
		// built capacity behaves as the full capacity.
		active = (entries_reg == 0) ? 1 :
			(int'(entries_reg) > CAPACITY) ? CAPACITY : int'(entries_reg);
		hit = -1;
		free_slot = -1;
		victim = -1;
		rsp = NO_RSP;
		for (int i = 0; i < active; i++) begin
			if (slot_valid[i]) begin
				// The lowest-numbered match wins when a key is stored twice.
				if (hit < 0 && slot_key[i] == k)
					hit = i;
				if (victim < 0 || slot_rank[i] > slot_rank[victim])
					victim = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (op == lks_pkg::CMD_ACCESS) begin
			if (hit >= 0) begin
				rsp.status = lks_pkg::STAT_HIT;
				rsp.value_out = slot_value[hit];
				make_recent(hit);
			end else begin
				rsp.status = lks_pkg::STAT_MISS;
			end
		end else if (hit >= 0) begin
			rsp.status = lks_pkg::STAT_UPDATED;
			slot_value[hit] = v;
			make_recent(hit);
		end else if (free_slot >= 0) begin
			// Every stored entry ages, including those beyond the active
			// count, and the new one becomes the most recent.
			rsp.status = lks_pkg::STAT_INS_FREE;
			for (int i = 0; i < CAPACITY; i++) begin
				if (slot_valid[i])
					slot_rank[i]++;
			end
			slot_valid[free_slot] = 1'b1;
			slot_key[free_slot] = k;
			slot_value[free_slot] = v;
			slot_rank[free_slot] = 0;
		end else begin
			rsp.status = lks_pkg::STAT_INS_EVICT;
			rsp.evicted_key = slot_key[victim];
			slot_key[victim] = k;
			slot_value[victim] = v;
			make_recent(victim);
		end
		return rsp;
	endfunction

	// Response side: checks every accepted response and draws a fresh random
	// stall after each one, or none while calm is set.
	int rsp_hold = 0;

	always @(posedge clk) begin
		lru_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: response with none outstanding: status %0d value %h evicted %h",
						$time, status, value_out, evicted_key);
					mismatch_count++;
				end else begin
					want = pending_rsp.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						mismatch_count++;
					end
					if (value_out !== want.value_out) begin
						$display("%0t: value_out expected %h actual %h",
							$time, want.value_out, value_out);
						mismatch_count++;
					end
					if (evicted_key !== want.evicted_key) begin
						$display("%0t: evicted_key expected %h actual %h",
							$time, want.evicted_key, evicted_key);
						mismatch_count++;
					end
				end
				rsp_hold = calm ? 0 : $urandom_range(0, 3);
			end else if (rsp_hold != 0) begin
				rsp_hold--;
			end
			rsp_ready <= (rsp_hold == 0);
		end
	end

	// Presents one request after a random gap, none while calm is set, and
	// waits for it to be taken. Valid is left high after acceptance so that a
	// back-to-back request does not lower and raise it in the same step; the
	// next gap or a drain lowers it.
	task automatic send_request(input logic op, input logic [lks_pkg::KEY_W-1:0] k,
			input logic [lks_pkg::VAL_W-1:0] v, input bit fixed, input lru_rsp_t fixed_rsp);
		int       gap;
		lru_rsp_t predicted;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= op;
		key <= k;
		value_in <= v;
		do
			@(posedge clk);
		while (!req_ready);
		predicted = lru_predict(op, k, v);
		pending_rsp.push_back(fixed ? fixed_rsp : predicted);
	endtask

	// Stops sending and waits until every outstanding response is back.
	task automatic drain_requests();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write of entries_in_use in a setup phase and an access phase, then a read
	// back of the register; the block must be idle.
	task automatic write_entries(input logic [lks_pkg::CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ENTRIES_ADDR;
		pwdata <= lks_pkg::PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		entries_reg = v;
		@(posedge clk);
		if (prdata !== lks_pkg::PDATA_W'(v)) begin
			$display("%0t: prdata expected %h actual %h",
				$time, lks_pkg::PDATA_W'(v), prdata);
			mismatch_count++;
		end
	endtask

	// Directed plan. The first rows run with all sixteen entries active and
	// are simple enough to write the response out by hand. The rest shrink
	// the active count to force evictions, use the out-of-range register
	// values, show that entries beyond a lowered count keep their contents,
	// and leave one key stored in two entries.
	plan_row_t directed_plan [PLAN_ROWS] = '{
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'h0000_0000, 32'h1234_5678, 1'b1,
			'{lks_pkg::STAT_MISS, 32'h0, 32'h0}},
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'h0, 1'b1,
			'{lks_pkg::STAT_MISS, 32'h0, 32'h0}},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'h0000_0000, 32'h8000_0000, 1'b1,
			'{lks_pkg::STAT_INS_FREE, 32'h0, 32'h0}},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
			'{lks_pkg::STAT_INS_FREE, 32'h0, 32'h0}},
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0, 1'b1,
			'{lks_pkg::STAT_HIT, 32'h8000_0000, 32'h0}},
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{lks_pkg::STAT_HIT, 32'h7FFF_FFFF, 32'h0}},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
			'{lks_pkg::STAT_UPDATED, 32'h0, 32'h0}},
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0, 1'b1,
			'{lks_pkg::STAT_HIT, 32'hFFFF_FFFF, 32'h0}},
		'{ROW_CONFIG, lks_pkg::CMD_ADD, 32'd2, 32'h0, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'h0000_0005, 32'h0000_0001, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'h0, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'h0000_0000, 32'h0000_0002, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'h0000_0006, 32'h0000_0003, 1'b0, NO_RSP},
		'{ROW_CONFIG, lks_pkg::CMD_ADD, 32'd0, 32'h0, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'h0000_0007, 32'h0000_0004, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'h0000_0006, 32'h0, 1'b0, NO_RSP},
		'{ROW_CONFIG, lks_pkg::CMD_ADD, 32'd31, 32'h0, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'h0000_0006, 32'h0, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, NO_RSP},
		'{ROW_CONFIG, lks_pkg::CMD_ADD, 32'd1, 32'h0, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'h0000_0006, 32'h0000_0005, 1'b0, NO_RSP},
		'{ROW_CONFIG, lks_pkg::CMD_ADD, 32'd16, 32'h0, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'h0000_0006, 32'h0, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ADD, 32'h0000_0006, 32'hC000_0001, 1'b0, NO_RSP},
		'{ROW_REQUEST, lks_pkg::CMD_ACCESS, 32'hA5A5_A5A5, 32'h0, 1'b0, NO_RSP}
	};

	// Active counts for the first random phases: the extremes, both
	// out-of-range directions and a few small sizes. Later phases draw
	// their own, mostly small so that evictions stay frequent.
	int phase_setting [7] = '{16, 1, 2, 0, 31, 3, 16};

	initial begin
		logic [lks_pkg::KEY_W-1:0] key_pool [CAPACITY + 4];
		logic [lks_pkg::KEY_W-1:0] req_key;
		logic [lks_pkg::VAL_W-1:0] req_value;
		logic [lks_pkg::CFG_W-1:0] setting;
		logic                      req_op;
		int                        active;
		int                        span;

		for (int i = 0; i < CAPACITY; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i] = '0;
			slot_value[i] = '0;
			slot_rank[i] = 0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: register writes are only made once the store has
		// returned every outstanding response.
		calm = 1'b0;
		foreach (directed_plan[r]) begin
			if (directed_plan[r].kind == ROW_CONFIG) begin
				drain_requests();
				write_entries(lks_pkg::CFG_W'(directed_plan[r].key));
			end else begin
				send_request(directed_plan[r].cmd, directed_plan[r].key,
					directed_plan[r].value, directed_plan[r].fixed_rsp,
					directed_plan[r].rsp);
			end
		end

		// Random part. Keys mostly come from a small pool, a few more than
		// the active count, so that hits, updates and evictions all happen
		// often; the rest are fully random. The pool is refilled each phase.
		for (int p = 0; p < PHASES; p++) begin
			drain_requests();
			if (p < 7)
				setting = lks_pkg::CFG_W'(phase_setting[p]);
			else if ($urandom_range(0, 1) == 0)
				setting = lks_pkg::CFG_W'($urandom_range(1, 6));
			else
				setting = lks_pkg::CFG_W'($urandom_range(0, 31));
			write_entries(setting);
			// The first random phase and roughly one in four of the rest
			// run without any idle cycles on either side.
			calm = (p == 0) || ($urandom_range(0, 3) == 0);

			active = (setting == 0) ? 1 :
				(int'(setting) > CAPACITY) ? CAPACITY : int'(setting);
			span = active + 3;
			foreach (key_pool[i])
				key_pool[i] = $urandom;
			if ($urandom_range(0, 1) == 0) begin
				key_pool[0] = '0;
				key_pool[1] = '1;
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Now and then the sender stops until the store has
				// answered everything it was given.
				if ($urandom_range(0, 63) == 0)
					drain_requests();
				req_op = ($urandom_range(0, 1) == 0) ? lks_pkg::CMD_ADD
					: lks_pkg::CMD_ACCESS;
				if ($urandom_range(0, 7) == 0)
					req_key = $urandom;
				else
					req_key = key_pool[$urandom_range(0, span - 1)];
				case ($urandom_range(0, 15))
					0: req_value = 32'h8000_0000;
					1: req_value = 32'h7FFF_FFFF;
					2: req_value = '1;
					default: req_value = $urandom;
				endcase
				send_request(req_op, req_key, req_value, 1'b0, NO_RSP);
			end
		end

		// Let the last responses come back, then allow time for anything
		// unexpected to show up.
		drain_requests();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && pending_rsp.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
